### rtl/ats_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types, widths and codes of the animated texture sampler.
// ----------------------------------------------------------------------------
package ats_pkg;

   localparam int MAX_FRAMES  = 4;
   localparam int MAX_DIM     = 64;

   localparam int FRAME_W     = $clog2(MAX_FRAMES);
   localparam int COORD_W     = $clog2(MAX_DIM);
   localparam int ADDR_W      = FRAME_W + 2 * COORD_W;
   localparam int STORE_DEPTH = MAX_FRAMES * MAX_DIM * MAX_DIM;

   localparam int DIM_W       = 7;
   localparam int COUNT_W     = 3;
   localparam int PERIOD_W    = 32;
   localparam int TEXEL_W     = 32;
   localparam int FRAC_W      = 16;
   localparam int MODE_W      = 2;
   localparam int CHAN_W      = 8;

   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // item modes
   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_COUNT  = 2'd2;
   localparam logic [1:0] REG_PERIOD = 2'd3;

   typedef struct packed {
      logic [DIM_W-1:0]    tex_width;
      logic [DIM_W-1:0]    tex_height;
      logic [COUNT_W-1:0]  frame_count;
      logic [PERIOD_W-1:0] frame_period_ticks;
   } cfg_type;

   // one command handed from the front to the back
   typedef struct packed {
      logic                is_read;
      logic                hit;
      logic [FRAME_W-1:0]  frame;
      logic [ADDR_W-1:0]   addr;
      logic [TEXEL_W-1:0]  wdata;
   } cmd_type;

endpackage
`default_nettype wire

### rtl/ats_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ats_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[addr] <= wdata;
      end
      rdata_ff <= store_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### rtl/ats_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_front
// Accepts items, runs the animation clock and turns writes and samples into
// texel store commands.
// ----------------------------------------------------------------------------
module ats_front
   import ats_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [MODE_W-1:0]     req_tuser,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire cfg_type               cfg,
   input  wire logic                  q_full,
   output logic                       q_push,
   output cmd_type                    q_cmd
);

   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [PERIOD_W-1:0] ticks_ff, ticks_in;

   logic                     accept;
   logic [MODE_W-1:0]        mode;
   logic [FRAC_W-1:0]        u_frac, v_frac;
   logic [FRAME_W-1:0]       load_frame;
   logic [COORD_W-1:0]       load_x, load_y;
   logic [TEXEL_W-1:0]       load_texel;
   logic [COUNT_W-1:0]       count;
   logic [DIM_W-1:0]         w_eff, h_eff;
   logic [FRAC_W+DIM_W-1:0]  u_prod, v_prod;
   logic [DIM_W-1:0]         x_raw, y_raw;
   logic [COORD_W-1:0]       x_pos, y_pos;
   logic                     hit, load_ok;
   logic [PERIOD_W-1:0]      ticks_inc;
   logic [COUNT_W-1:0]       frame_nxt;

   assign mode       = req_tuser;
   assign u_frac     = req_tdata[FRAC_W-1:0];
   assign v_frac     = req_tdata[32 +: FRAC_W];
   assign load_frame = req_tdata[64 +: FRAME_W];
   assign load_x     = req_tdata[66 +: COORD_W];
   assign load_y     = req_tdata[72 +: COORD_W];
   assign load_texel = req_tdata[78 +: TEXEL_W];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   assign count = (cfg.frame_count > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                          : cfg.frame_count;
   assign w_eff = (cfg.tex_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.tex_width;
   assign h_eff = (cfg.tex_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.tex_height;

   // repeat wrap: keep the Q0.16 fraction, scale by the dimension, truncate
   assign u_prod = (FRAC_W+DIM_W)'(u_frac) * (FRAC_W+DIM_W)'(w_eff);
   assign v_prod = (FRAC_W+DIM_W)'(v_frac) * (FRAC_W+DIM_W)'(h_eff);
   assign x_raw  = u_prod[FRAC_W +: DIM_W];
   assign y_raw  = v_prod[FRAC_W +: DIM_W];
   assign x_pos  = (x_raw >= DIM_W'(MAX_DIM)) ? COORD_W'(MAX_DIM - 1) : x_raw[COORD_W-1:0];
   assign y_pos  = (y_raw >= DIM_W'(MAX_DIM)) ? COORD_W'(MAX_DIM - 1) : y_raw[COORD_W-1:0];

   assign hit     = (count != '0) && (COUNT_W'(frame_ff) < count);
   assign load_ok = (COUNT_W'(load_frame) < COUNT_W'(MAX_FRAMES))
                 && (DIM_W'(load_x) < DIM_W'(MAX_DIM))
                 && (DIM_W'(load_y) < DIM_W'(MAX_DIM));

   always_comb begin
      q_push = 1'b0;
      q_cmd  = '0;
      case (mode)
         MODE_WRITE: begin
            q_push        = accept && load_ok;
            q_cmd.is_read = 1'b0;
            q_cmd.addr    = {load_frame, load_y, load_x};
            q_cmd.wdata   = load_texel;
         end
         MODE_SAMPLE: begin
            q_push        = accept;
            q_cmd.is_read = 1'b1;
            q_cmd.hit     = hit;
            q_cmd.frame   = hit ? frame_ff : '0;
            q_cmd.addr    = {frame_ff, y_pos, x_pos};
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   // animation clock
   assign ticks_inc = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;
   always_comb begin
      frame_nxt = COUNT_W'(frame_ff) + 1'b1;
      if (frame_nxt >= count) begin
         frame_nxt = frame_nxt - count;
      end
      // a stale frame above a lowered count can need a second wrap
      if (frame_nxt >= count) begin
         frame_nxt = frame_nxt - count;
      end
   end

   always_comb begin
      frame_in = frame_ff;
      ticks_in = ticks_ff;
      if (accept && mode == MODE_TICK && count > COUNT_W'(1)
          && cfg.frame_period_ticks != '0) begin
         if (ticks_inc >= cfg.frame_period_ticks) begin
            frame_in = frame_nxt[FRAME_W-1:0];
            ticks_in = '0;
         end else begin
            ticks_in = ticks_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         ticks_ff <= '0;
      end else begin
         frame_ff <= frame_in;
         ticks_ff <= ticks_in;
      end
   end

`ifndef SYNTH
   a_frame_holds_without_period: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == MODE_TICK && cfg.frame_period_ticks == '0) |=> $stable(frame_ff))
      else $error("frame advanced with animation disabled");
`endif

endmodule
`default_nettype wire

### rtl/ats_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ats_queue
   import ats_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic                do_push, do_pop;

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      end
   end

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

### rtl/ats_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_back
// Executes queued commands on the texel store and holds the result item.
// ----------------------------------------------------------------------------
module ats_back
   import ats_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire cmd_type               head_cmd,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic                pend_ff;
   logic                pend_hit_ff;
   logic [FRAME_W-1:0]  pend_frame_ff;
   logic                out_valid_ff, out_valid_in;
   logic [TEXEL_W-1:0]  out_texel_ff;
   logic [FRAME_W-1:0]  out_frame_ff;
   logic                slot_free;
   logic [TEXEL_W-1:0]  rdata;

   // a read may start only if its result finds the output register empty
   assign slot_free = !pend_ff && (!out_valid_ff || rsp_tready);
   assign pop       = head_valid && (!head_cmd.is_read || slot_free);

   ats_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (pop && !head_cmd.is_read),
      .addr  (head_cmd.addr),
      .wdata (head_cmd.wdata),
      .rdata (rdata)
   );

   assign out_valid_in = pend_ff || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pop && head_cmd.is_read;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pend_hit_ff   <= head_cmd.hit;
         pend_frame_ff <= head_cmd.frame;
      end
      if (pend_ff) begin
         out_texel_ff <= pend_hit_ff ? rdata : '0;
         out_frame_ff <= pend_frame_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_frame_ff,
                        out_texel_ff[7:0],     // alpha
                        out_texel_ff[15:8],    // blue
                        out_texel_ff[23:16],   // green
                        out_texel_ff[31:24]};  // red

`ifndef SYNTH
   a_pend_finds_free_slot: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !out_valid_ff)
      else $error("read data arrived at a full output register");
   a_read_pop_pends: assert property (@(posedge clock) disable iff (reset)
      (pop && head_cmd.is_read) |=> (pend_ff && out_valid_in))
      else $error("popped read did not reach the output register");
   a_no_write_while_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> $stable(out_texel_ff))
      else $error("held result changed under stall");
`endif

endmodule
`default_nettype wire

### rtl/animated_texture_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// animated_texture_sampler
// Nearest-texel sampler with repeat wrap over up to four animation frames.
// ----------------------------------------------------------------------------
//  channel | ports | role
//  req     | req_tvalid/tready, tuser=mode, tdata=coords+load fields | items in
//  rsp     | rsp_tvalid/tready, tdata=channels+frame | sample results
//  csr     | csr_psel/penable/pwrite/paddr/pwdata/prdata/pready | registers
//
//  Writes and ticks are taken one per cycle while the command queue is not
//  full; a sample occupies the back end through the registered texel store
//  read and then the output register, from which rsp_tvalid is driven.
//  Reset clears control state only; the texel store is undefined until written.
//  A two-entry command queue lets input and output stall independently.
// ----------------------------------------------------------------------------
module animated_texture_sampler
   import ats_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [MODE_W-1:0]     req_tuser,  // mode
   // u_coord, v_coord, load_frame, load_x, load_y, load_texel, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // red, green, blue, alpha, shown_frame, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cfg_type  cfg_ff;
   logic     csr_write;
   logic     q_full, q_push, q_pop, q_head_valid;
   cmd_type  q_cmd, q_head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tex_width          <= DIM_W'(MAX_DIM);
         cfg_ff.tex_height         <= DIM_W'(MAX_DIM);
         cfg_ff.frame_count        <= '0;
         cfg_ff.frame_period_ticks <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_WIDTH:  cfg_ff.tex_width          <= csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: cfg_ff.tex_height         <= csr_pwdata[DIM_W-1:0];
            REG_COUNT:  cfg_ff.frame_count        <= csr_pwdata[COUNT_W-1:0];
            REG_PERIOD: cfg_ff.frame_period_ticks <= csr_pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.tex_width);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.tex_height);
         REG_COUNT:  csr_prdata = CSR_DATA_W'(cfg_ff.frame_count);
         REG_PERIOD: csr_prdata = CSR_DATA_W'(cfg_ff.frame_period_ticks);
         default:    csr_prdata = '0;
      endcase
   end

   ats_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   ats_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head)
   );

   ats_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_cmd   (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

### test/animated_texture_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animated_texture_sampler_tb
// Streams texel writes, samples and ticks into the sampler and checks every
// sample result against a shadow copy of the texel store and animation state.
// A directed table covers reset, wrap, saturation and stale-frame behavior;
// random phases follow under changing settings and flow-control patterns.
// ----------------------------------------------------------------------------
module animated_texture_sampler_tb;
   import ats_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS = 62;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [31:0]        u_coord;
      logic [31:0]        v_coord;
      logic [FRAME_W-1:0] load_frame;
      logic [COORD_W-1:0] load_x;
      logic [COORD_W-1:0] load_y;
      logic [TEXEL_W-1:0] load_texel;
   } req_item_type;

   typedef struct {
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha;
      logic [FRAME_W-1:0] frame;
   } sample_type;

   typedef struct {
      bit           is_reg;
      logic [1:0]   reg_idx;
      logic [31:0]  reg_val;
      req_item_type item;
      bit           typed;
      sample_type   want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [MODE_W-1:0]     req_tuser;   // mode
   // u_coord, v_coord, load_frame, load_x, load_y, load_texel, zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // red, green, blue, alpha, shown_frame, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   animated_texture_sampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // shadow of the sampler state
   logic [TEXEL_W-1:0] texel_copy [STORE_DEPTH];
   bit                 texel_set  [STORE_DEPTH];
   int unsigned        anim_frame;
   logic [31:0]        anim_ticks;
   logic [DIM_W-1:0]   cfg_width;
   logic [DIM_W-1:0]   cfg_height;
   logic [COUNT_W-1:0] cfg_count;
   logic [31:0]        cfg_period;

   sample_type   pending_samples [$];
   plan_row_type plan [$];

   int errors;
   int items_sent;
   int samples_checked;
   int reg_writes;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_req;
   bit hold_ack;
   int hold_left;
   sample_type got;
   sample_type exp_s;

   function automatic void add_row(input plan_row_type r);
      plan.insert(plan.size(), r);
   endfunction

   function automatic void expect_sample(input sample_type s);
      pending_samples.insert(pending_samples.size(), s);
   endfunction

   function automatic int unsigned frames_live();
      return (cfg_count > MAX_FRAMES) ? MAX_FRAMES : cfg_count;
   endfunction

   function automatic int unsigned dim_limit(input logic [DIM_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : d;
   endfunction

   function automatic sample_type to_sample(input logic [31:0] texel, input int unsigned frame);
      sample_type s;
      s.red   = texel[31:24];
      s.green = texel[23:16];
      s.blue  = texel[15:8];
      s.alpha = texel[7:0];
      s.frame = frame[FRAME_W-1:0];
      return s;
   endfunction

   // store address a sample reads, or 0 when it reads nothing
   function automatic bit texel_addr(input logic [31:0] u, input logic [31:0] v,
                                     output logic [ADDR_W-1:0] a);
      int unsigned cnt;
      int unsigned x;
      int unsigned y;
      cnt = frames_live();
      a = '0;
      if (cnt == 0 || anim_frame >= cnt) return 1'b0;
      x = u[FRAC_W-1:0];
      y = v[FRAC_W-1:0];
      x = (x * dim_limit(cfg_width)) >> FRAC_W;
      y = (y * dim_limit(cfg_height)) >> FRAC_W;
      if (x >= MAX_DIM) x = MAX_DIM - 1;
      if (y >= MAX_DIM) y = MAX_DIM - 1;
      a = ADDR_W'((anim_frame * MAX_DIM + y) * MAX_DIM + x);
      return 1'b1;
   endfunction

   function automatic void process_item(input req_item_type it, output bit produces,
                                        output sample_type s);
      int unsigned cnt;
      logic [ADDR_W-1:0] a;
      cnt = frames_live();
      produces = 1'b0;
      s = to_sample(32'd0, 0);
      case (it.mode)
         MODE_WRITE: begin
            a = {it.load_frame, it.load_y, it.load_x};
            texel_copy[a] = it.load_texel;
            texel_set[a] = 1'b1;
         end
         MODE_SAMPLE: begin
            produces = 1'b1;
            if (texel_addr(it.u_coord, it.v_coord, a)) s = to_sample(texel_copy[a], anim_frame);
         end
         MODE_TICK: begin
            if (cnt > 1 && cfg_period != 0) begin
               if (anim_ticks != 32'hFFFF_FFFF) anim_ticks = anim_ticks + 1;
               if (anim_ticks >= cfg_period) begin
                  anim_frame = (anim_frame + 1) % cnt;
                  anim_ticks = 0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic plan_row_type item_row(input logic [MODE_W-1:0] mode,
                                             input logic [31:0] u, input logic [31:0] v,
                                             input logic [1:0] f, input logic [5:0] x,
                                             input logic [5:0] y, input logic [31:0] texel);
      plan_row_type r;
      r.is_reg = 1'b0;
      r.reg_idx = '0;
      r.reg_val = '0;
      r.typed = 1'b0;
      r.want = to_sample(32'd0, 0);
      r.item.mode = mode;
      r.item.u_coord = u;
      r.item.v_coord = v;
      r.item.load_frame = f;
      r.item.load_x = x;
      r.item.load_y = y;
      r.item.load_texel = texel;
      return r;
   endfunction

   function automatic plan_row_type checked_row(input logic [31:0] u, input logic [31:0] v,
                                                input logic [31:0] texel,
                                                input int unsigned frame);
      plan_row_type r;
      r = item_row(MODE_SAMPLE, u, v, 2'd0, 6'd0, 6'd0, 32'd0);
      r.typed = 1'b1;
      r.want = to_sample(texel, frame);
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [1:0] idx, input logic [31:0] val);
      plan_row_type r;
      r = item_row(MODE_UNUSED, 32'd0, 32'd0, 2'd0, 6'd0, 6'd0, 32'd0);
      r.is_reg = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   function automatic logic [31:0] pick_dim();
      case ($urandom_range(0, 5))
         0: return 32'd1;
         1: return MAX_DIM;
         2: return 32'd127;
         5: return $urandom_range(0, 127);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   task automatic send_item(input req_item_type it, input bit typed, input sample_type want);
      bit produces;
      sample_type s;
      process_item(it, produces, s);
      if (typed) s = want;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.mode;
      req_tdata <= {2'b00, it.load_texel, it.load_y, it.load_x, it.load_frame,
                    it.v_coord, it.u_coord};
      do @(posedge clock); while (!req_tready);
      if (produces) expect_sample(s);
      if (it.mode != MODE_UNUSED) items_sent++;
   endtask

   // hold input until every result is back and the back end has gone quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [1:0] idx, input logic [31:0] val,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] mask;
      logic [31:0] rdata;
      drain();
      case (idx)
         REG_WIDTH, REG_HEIGHT: mask = 32'h7F;
         REG_COUNT:             mask = 32'h7;
         default:               mask = 32'hFFFF_FFFF;
      endcase
      csr_access(1'b1, idx, val, rdata);
      csr_access(1'b0, idx, 32'd0, rdata);
      if ((rdata & mask) != (val & mask)) begin
         $error("register %0d: expected %0h, got %0h", idx, val & mask, rdata & mask);
         errors++;
      end
      case (idx)
         REG_WIDTH:  cfg_width = val[DIM_W-1:0];
         REG_HEIGHT: cfg_height = val[DIM_W-1:0];
         REG_COUNT:  cfg_count = val[COUNT_W-1:0];
         default:    cfg_period = val;
      endcase
      reg_writes++;
   endtask

   // result side: check each item, then decide the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red   = rsp_tdata[7:0];
         got.green = rsp_tdata[15:8];
         got.blue  = rsp_tdata[23:16];
         got.alpha = rsp_tdata[31:24];
         got.frame = rsp_tdata[33:32];
         if (pending_samples.size() == 0) begin
            $error("result with nothing expected: %0h", rsp_tdata);
            errors++;
         end else begin
            exp_s = pending_samples.pop_front();
            samples_checked++;
            if (got.red !== exp_s.red) begin
               $error("red: expected %0h, got %0h", exp_s.red, got.red);
               errors++;
            end
            if (got.green !== exp_s.green) begin
               $error("green: expected %0h, got %0h", exp_s.green, got.green);
               errors++;
            end
            if (got.blue !== exp_s.blue) begin
               $error("blue: expected %0h, got %0h", exp_s.blue, got.blue);
               errors++;
            end
            if (got.alpha !== exp_s.alpha) begin
               $error("alpha: expected %0h, got %0h", exp_s.alpha, got.alpha);
               errors++;
            end
            if (got.frame !== exp_s.frame) begin
               $error("shown_frame: expected %0d, got %0d", exp_s.frame, got.frame);
               errors++;
            end
         end
      end
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         hold_left <= 0;
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("animated_texture_sampler_tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      req_item_type it;
      req_item_type fill;
      sample_type none_s;
      logic [ADDR_W-1:0] a;
      int phase;
      int phase_items;
      int r;
      int unsigned dim;
      bit stall_done;
      bit pause_done;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= '0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      hold_req = 1'b0;
      hold_ack = 1'b0;
      hold_left = 0;
      errors = 0;
      items_sent = 0;
      samples_checked = 0;
      reg_writes = 0;
      cycle_count = 0;
      send_idle_pct = 12;
      recv_idle_pct = 75;
      anim_frame = 0;
      anim_ticks = 0;
      cfg_width = 7'd64;
      cfg_height = 7'd64;
      cfg_count = 3'd0;
      cfg_period = 32'd0;
      stall_done = 1'b0;
      pause_done = 1'b0;
      none_s = to_sample(32'd0, 0);
      foreach (texel_set[i]) texel_set[i] = 1'b0;

      // no frames after reset, then corners, negatives, wrap, stale frame, saturation
      add_row(checked_row(32'h0000_0000, 32'h0000_0000, 32'h0, 0));
      add_row(item_row(MODE_WRITE, 32'h0, 32'h0, 2'd0, 6'd0, 6'd0, 32'h1122_3344));
      add_row(item_row(MODE_WRITE, 32'h0, 32'h0, 2'd0, 6'd63, 6'd63, 32'hFFFF_FFFF));
      add_row(item_row(MODE_WRITE, 32'h0, 32'h0, 2'd0, 6'd0, 6'd63, 32'h00FF_00FF));
      add_row(item_row(MODE_WRITE, 32'h0, 32'h0, 2'd0, 6'd63, 6'd0, 32'h0000_FF00));
      add_row(item_row(MODE_WRITE, 32'h0, 32'h0, 2'd1, 6'd0, 6'd0, 32'hA5A5_A5A5));
      add_row(item_row(MODE_WRITE, 32'h0, 32'h0, 2'd3, 6'd63, 6'd63, 32'h5A5A_5A5A));
      add_row(csr_row(REG_COUNT, 32'd2));
      add_row(checked_row(32'h0000_0000, 32'h0000_0000, 32'h1122_3344, 0));
      add_row(checked_row(32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 0));
      add_row(item_row(MODE_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 2'd0, 6'd0, 6'd0,
                       32'h0));
      add_row(item_row(MODE_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_0000, 2'd0, 6'd0, 6'd0,
                       32'h0));
      add_row(csr_row(REG_PERIOD, 32'd1));
      add_row(item_row(MODE_TICK, 32'h0, 32'h0, 2'd0, 6'd0, 6'd0, 32'h0));
      add_row(checked_row(32'h0000_0000, 32'h0000_0000, 32'hA5A5_A5A5, 1));
      add_row(item_row(MODE_UNUSED, 32'hDEAD_BEEF, 32'h1234_5678, 2'd2, 6'd5, 6'd9,
                       32'hCAFE_F00D));
      add_row(csr_row(REG_COUNT, 32'd1));
      add_row(checked_row(32'h0000_0000, 32'h0000_0000, 32'h0, 0));
      add_row(item_row(MODE_TICK, 32'h0, 32'h0, 2'd0, 6'd0, 6'd0, 32'h0));
      add_row(csr_row(REG_COUNT, 32'd7));
      add_row(csr_row(REG_WIDTH, 32'd0));
      add_row(csr_row(REG_HEIGHT, 32'd127));
      add_row(item_row(MODE_WRITE, 32'h0, 32'h0, 2'd1, 6'd0, 6'd63, 32'h1234_5678));
      add_row(item_row(MODE_SAMPLE, 32'h0000_FFFF, 32'h0000_FFFF, 2'd0, 6'd0, 6'd0,
                       32'h0));
      add_row(csr_row(REG_WIDTH, 32'd65));
      add_row(csr_row(REG_HEIGHT, 32'd0));
      add_row(item_row(MODE_WRITE, 32'h0, 32'h0, 2'd1, 6'd63, 6'd0, 32'h8765_4321));
      add_row(item_row(MODE_SAMPLE, 32'h0000_FFFF, 32'h0000_FFFF, 2'd0, 6'd0, 6'd0,
                       32'h0));
      repeat (3) add_row(item_row(MODE_TICK, 32'h0, 32'h0, 2'd0, 6'd0, 6'd0, 32'h0));
      add_row(item_row(MODE_SAMPLE, 32'h0, 32'h0, 2'd0, 6'd0, 6'd0, 32'h0));
      add_row(csr_row(REG_PERIOD, 32'd0));
      add_row(item_row(MODE_TICK, 32'h0, 32'h0, 2'd0, 6'd0, 6'd0, 32'h0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_reg) set_reg(plan[i].reg_idx, plan[i].reg_val);
         else send_item(plan[i].item, plan[i].typed, plan[i].want);
      end

      for (phase = 0; phase < 6; phase++) begin
         drain();
         send_idle_pct = (phase < 2) ? 12 : (phase < 4) ? 75 : 0;
         recv_idle_pct = (phase < 2) ? 75 : (phase < 4) ? 12 : 0;
         set_reg(REG_WIDTH, pick_dim());
         set_reg(REG_HEIGHT, pick_dim());
         set_reg(REG_COUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                        : $urandom_range(2, 4));
         case ($urandom_range(0, 6))
            0: set_reg(REG_PERIOD, 32'd0);
            1: set_reg(REG_PERIOD, 32'hFFFF_FFFF);
            2: set_reg(REG_PERIOD, 32'd1);
            default: set_reg(REG_PERIOD, $urandom_range(1, 6));
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            // long receiver stall while items keep coming
            if (phase == 1 && phase_items >= 10 && !stall_done) begin
               hold_req = ~hold_req;
               stall_done = 1'b1;
            end
            // sender waits for every result before going on
            if (phase == 3 && phase_items >= 30 && !pause_done) begin
               req_tvalid <= 1'b0;
               while (pending_samples.size() != 0) @(posedge clock);
               pause_done = 1'b1;
            end
            it.u_coord = $urandom;
            it.v_coord = $urandom;
            it.load_frame = FRAME_W'($urandom_range(0, 3));
            it.load_x = COORD_W'($urandom_range(0, 63));
            it.load_y = COORD_W'($urandom_range(0, 63));
            it.load_texel = $urandom;
            r = $urandom_range(0, 99);
            if (r < 50) begin
               it.mode = MODE_SAMPLE;
               if (texel_addr(it.u_coord, it.v_coord, a) && !texel_set[a]) begin
                  fill = it;
                  fill.mode = MODE_WRITE;
                  fill.load_frame = a[ADDR_W-1 -: FRAME_W];
                  fill.load_y = a[2*COORD_W-1 -: COORD_W];
                  fill.load_x = a[COORD_W-1:0];
                  fill.load_texel = $urandom;
                  send_item(fill, 1'b0, none_s);
                  phase_items++;
               end
            end else if (r < 78) begin
               it.mode = MODE_WRITE;
               // keep half the writes inside the area being sampled
               if ($urandom_range(0, 1) == 0) begin
                  dim = dim_limit(cfg_width);
                  it.load_x = COORD_W'($urandom_range(0, (dim == 0) ? 0 : dim - 1));
                  dim = dim_limit(cfg_height);
                  it.load_y = COORD_W'($urandom_range(0, (dim == 0) ? 0 : dim - 1));
                  it.load_frame = anim_frame[FRAME_W-1:0];
               end
            end else if (r < 96) begin
               it.mode = MODE_TICK;
            end else begin
               it.mode = MODE_UNUSED;
            end
            send_item(it, 1'b0, none_s);
            if (it.mode != MODE_UNUSED) phase_items++;
         end
      end

      drain();
      $display("%0d items sent, %0d samples checked, %0d register writes",
               items_sent, samples_checked, reg_writes);
      $display("covered wrap, saturation, stale frames, animation and flow-control stalls");
      if (errors == 0 && pending_samples.size() == 0) begin
         $display("animated_texture_sampler_tb: clean");
      end else begin
         $display("animated_texture_sampler_tb: errors");
      end
      $finish;
   end

endmodule
